// ===== sv/stbg_pkg.sv =====
// ----------------------------------------------------------------------------
// stbg_pkg: shared definitions for the sine tone burst generator
// Register map, field widths and the quarter-wave amplitude function.
// ----------------------------------------------------------------------------
`default_nettype none

package stbg_pkg;

   localparam int PHASE_BITS_DEFAULT      = 32;
   localparam int TABLE_ADDR_BITS_DEFAULT = 8;

   localparam int STEP_BITS   = 32;
   localparam int GAIN_BITS   = 17;
   localparam int COUNT_BITS  = 24;
   localparam int SAMPLE_BITS = 16;
   localparam int AMP_BITS    = 15;
   localparam int PROD_BITS   = AMP_BITS + GAIN_BITS;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [GAIN_BITS-1:0]  GAIN_FULL  = 17'd65536;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 17'd19661;

   typedef enum logic [1:0] {
      REG_PHASE_STEP   = 2'd0,
      REG_GAIN         = 2'd1,
      REG_TONE_SAMPLES = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] AMP_SCALE   = 64'd32767;

   // Rounded 32767*sin(pi/2 * k / 2^addr_bits), from a fixed-point
   // Taylor series in Q2.30. Only evaluated at elaboration.
   function automatic logic [AMP_BITS-1:0] quarter_amp(input int unsigned k,
                                                       input int unsigned addr_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] a;
      x  = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      a  = (s * AMP_SCALE + (Q30_ONE >> 1)) >> 30;
      return a[AMP_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/sine_tone_burst_generator.sv =====
// ----------------------------------------------------------------------------
// sine_tone_burst_generator: direct digital synthesis tone bursts
// An accepted request item passes the stage 1, 2 and 3 registers to become a response item.
// Throughput: one item per cycle unless rsp_ready stalls the output; the phase update, the
// synchronous sine table read and the gain multiply sit in separate pipeline stages.
// Reset (synchronous, active high) clears the phase, the burst counter, the
// pipeline valids and the registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_burst_generator
   import stbg_pkg::*;
#(
   parameter int PHASE_BITS      = PHASE_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_start_req,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_active,
   output logic                          rsp_last,
   // configuration port
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int TABLE_DEPTH = (1 << TABLE_ADDR_BITS) + 1;
   localparam int TOP_LSB     = PHASE_BITS - TABLE_ADDR_BITS - 2;
   localparam logic [TABLE_ADDR_BITS:0] QUARTER =
      (TABLE_ADDR_BITS+1)'(1) << TABLE_ADDR_BITS;

   typedef logic [AMP_BITS-1:0] amp_table_type [TABLE_DEPTH];

   function automatic amp_table_type build_amp_table();
      amp_table_type tbl;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl[i] = quarter_amp(i, TABLE_ADDR_BITS);
      end
      return tbl;
   endfunction

   localparam amp_table_type AMP_TABLE = build_amp_table();

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [STEP_BITS-1:0]  phase_step_ff,   phase_step_in;
   logic [GAIN_BITS-1:0]  gain_ff,         gain_in;
   logic [COUNT_BITS-1:0] tone_samples_ff, tone_samples_in;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      phase_step_in   = phase_step_ff;
      gain_in         = gain_ff;
      tone_samples_in = tone_samples_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PHASE_STEP:   phase_step_in   = csr_pwdata;
            REG_GAIN:         gain_in         = csr_pwdata[GAIN_BITS-1:0];
            REG_TONE_SAMPLES: tone_samples_in = csr_pwdata[COUNT_BITS-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PHASE_STEP:   csr_prdata = phase_step_ff;
         REG_GAIN:         csr_prdata = CSR_DATA_BITS'(gain_ff);
         REG_TONE_SAMPLES: csr_prdata = CSR_DATA_BITS'(tone_samples_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         gain_ff         <= GAIN_RESET;
         tone_samples_ff <= '0;
      end else begin
         phase_step_ff   <= phase_step_in;
         gain_ff         <= gain_in;
         tone_samples_ff <= tone_samples_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control: each stage moves when the one after it is free.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic en1, en2, en3;
   logic accept;

   assign en3       = ~s3_valid_ff | rsp_ready;
   assign en2       = ~s2_valid_ff | en3;
   assign en1       = ~s1_valid_ff | en2;
   assign req_ready = en1;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= accept;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 0: burst state update and table address
   // ------------------------------------------------------------------------
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [COUNT_BITS-1:0]    left_ff,  left_in;
   logic [PHASE_BITS-1:0]    cur_phase;
   logic [COUNT_BITS-1:0]    cur_left;
   logic                     cur_active;
   logic                     cur_last;
   logic [1:0]               quadrant;
   logic [TABLE_ADDR_BITS:0] step_k;
   logic [TABLE_ADDR_BITS:0] rom_addr;
   logic [GAIN_BITS-1:0]     gain_sat;

   always_comb begin
      cur_phase  = req_start_req ? '0 : phase_ff;
      cur_left   = req_start_req ? tone_samples_ff : left_ff;
      cur_active = (cur_left != '0);
      cur_last   = (cur_left == COUNT_BITS'(1));
      phase_in   = phase_ff;
      left_in    = left_ff;
      if (accept) begin
         phase_in = cur_phase;
         left_in  = cur_left;
         if (cur_active) begin
            phase_in = cur_phase + PHASE_BITS'(phase_step_ff);
            left_in  = cur_left - COUNT_BITS'(1);
         end
      end
   end

   // Odd quadrants run the quarter wave backwards.
   assign quadrant = cur_phase[PHASE_BITS-1 -: 2];
   assign step_k   = {1'b0, cur_phase[TOP_LSB +: TABLE_ADDR_BITS]};
   assign rom_addr = quadrant[0] ? (QUARTER - step_k) : step_k;
   assign gain_sat = (gain_ff > GAIN_FULL) ? GAIN_FULL : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: synchronous sine table read
   // ------------------------------------------------------------------------
   logic [AMP_BITS-1:0]  s1_amp_ff;
   logic [GAIN_BITS-1:0] s1_gain_ff;
   logic                 s1_neg_ff, s1_active_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_amp_ff    <= AMP_TABLE[rom_addr];
         s1_gain_ff   <= gain_sat;
         s1_neg_ff    <= quadrant[1];
         s1_active_ff <= cur_active;
         s1_last_ff   <= cur_active & cur_last;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: gain multiply
   // ------------------------------------------------------------------------
   logic [PROD_BITS-1:0] s2_prod_ff;
   logic                 s2_neg_ff, s2_active_ff, s2_last_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_prod_ff   <= PROD_BITS'(s1_amp_ff) * PROD_BITS'(s1_gain_ff);
         s2_neg_ff    <= s1_neg_ff;
         s2_active_ff <= s1_active_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: sign, idle zeroing and output register
   // ------------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] sample_in;

   // The magnitude never exceeds 32767, so negation cannot overflow.
   assign mag = s2_prod_ff[PROD_BITS-1 -: SAMPLE_BITS];

   always_comb begin
      if (!s2_active_ff) begin
         sample_in = '0;
      end else if (s2_neg_ff) begin
         sample_in = '0 - mag;
      end else begin
         sample_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_sample <= sample_in;
         rsp_active <= s2_active_ff;
         rsp_last   <= s2_last_ff;
      end
   end

   assign rsp_valid = s3_valid_ff;

endmodule

`default_nettype wire
